// File: rtl/rlsf_pkg.sv
// ----------------------------------------------------------------------------
// Load/store formatter package
// Shared widths, codes and types of the register load/store formatter.
// ----------------------------------------------------------------------------
package rlsf_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned NumBytes = DataW / 8;
  localparam int unsigned SizeW    = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_BIG_ENDIAN  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET_MODE = 2'd1;

  // Target modes; the remaining code behaves as plain.
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_SEXT  = 2'd1;
  localparam logic [1:0] MODE_ALPHA = 2'd2;

  // Transaction kinds.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_STORE = 1'b1;
  localparam logic KIND_INT   = 1'b0;
  localparam logic KIND_FLOAT = 1'b1;

  typedef struct packed {
    logic       big_endian;
    logic [1:0] target_mode;
  } cfg_t;

  typedef struct packed {
    logic             func;
    logic             reg_kind;
    logic [SizeW-1:0] access_size;
    logic [DataW-1:0] mem_bytes;
    logic [DataW-1:0] reg_value;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0]    reg_result;
    logic [DataW-1:0]    mem_result;
    logic [NumBytes-1:0] byte_mask;
  } rsp_t;

endpackage

// File: rtl/rlsf_if.sv
// ----------------------------------------------------------------------------
// Load/store formatter channels
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface rlsf_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic                         reg_kind;
  logic [rlsf_pkg::SizeW-1:0]   access_size;
  logic [rlsf_pkg::DataW-1:0]   mem_bytes;
  logic [rlsf_pkg::DataW-1:0]   reg_value;

  modport source (output valid, func, reg_kind, access_size, mem_bytes, reg_value,
                  input ready);
  modport sink   (input valid, func, reg_kind, access_size, mem_bytes, reg_value,
                  output ready);
endinterface

interface rlsf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rlsf_pkg::DataW-1:0]    reg_result;
  logic [rlsf_pkg::DataW-1:0]    mem_result;
  logic [rlsf_pkg::NumBytes-1:0] byte_mask;

  modport source (output valid, reg_result, mem_result, byte_mask, input ready);
  modport sink   (input valid, reg_result, mem_result, byte_mask, output ready);
endinterface

interface rlsf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rlsf_pkg::CfgIdxW-1:0]  index;
  logic [rlsf_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/rlsf_format.sv
// ----------------------------------------------------------------------------
// Load/store data formatter
// Byte ordering, sign extension and Alpha float conversion for one transaction.
// ----------------------------------------------------------------------------
module rlsf_format (
  input  rlsf_pkg::cfg_t cfg_i,
  input  rlsf_pkg::req_t req_i,
  output rlsf_pkg::rsp_t rsp_o
);

  // Maps an 8-bit single-precision exponent onto the 11-bit double range.
  function automatic logic [10:0] widen_exp(input logic [7:0] e);
    logic [10:0] r;
    if (e == 8'hFF) begin
      r = 11'h7FF;
    end else if (e == 8'h00) begin
      r = 11'h000;
    end else if (e[7]) begin
      r = 11'h400 | {4'b0, e[6:0]};
    end else begin
      r = 11'h380 | {4'b0, e[6:0]};
    end
    return r;
  endfunction

  logic [rlsf_pkg::SizeW-1:0]    size_n;
  logic                          sext_mode;
  logic                          alpha_mode;
  logic                          is_float;
  logic [rlsf_pkg::DataW-1:0]    load_raw;
  logic [rlsf_pkg::DataW-1:0]    load_val;
  logic [rlsf_pkg::DataW-1:0]    store_src;
  logic [rlsf_pkg::DataW-1:0]    store_val;
  logic [rlsf_pkg::NumBytes-1:0] mask;
  logic [rlsf_pkg::SizeW-1:0]    src_idx;

  assign size_n     = (req_i.access_size > 4'd8) ? 4'd8 : req_i.access_size;
  assign sext_mode  = (cfg_i.target_mode == rlsf_pkg::MODE_SEXT) ||
                      (cfg_i.target_mode == rlsf_pkg::MODE_ALPHA);
  assign alpha_mode = (cfg_i.target_mode == rlsf_pkg::MODE_ALPHA);
  assign is_float   = (req_i.reg_kind == rlsf_pkg::KIND_FLOAT);

  // In big-endian order byte j of the value comes from memory byte n-1-j.
  always_comb begin
    load_raw  = '0;
    store_val = '0;
    mask      = '0;
    src_idx   = '0;
    for (int j = 0; j < rlsf_pkg::NumBytes; j++) begin
      if (4'(j) < size_n) begin
        mask[j] = 1'b1;
        src_idx = cfg_i.big_endian ? (size_n - 4'd1 - 4'(j)) : 4'(j);
        load_raw[8*j +: 8]  = req_i.mem_bytes[8*src_idx[2:0] +: 8];
        store_val[8*j +: 8] = store_src[8*src_idx[2:0] +: 8];
      end
    end
  end

  always_comb begin
    load_val = load_raw;
    if (size_n == 4'd4) begin
      if (!is_float && sext_mode) begin
        load_val = {{32{load_raw[31]}}, load_raw[31:0]};
      end else if (is_float && alpha_mode) begin
        load_val = {load_raw[31], widen_exp(load_raw[30:23]), load_raw[22:0], 29'b0};
      end
    end
  end

  // A 4-byte Alpha float store keeps sign, top exponent bit and bits 58:29.
  always_comb begin
    store_src = req_i.reg_value;
    if (is_float && alpha_mode && size_n == 4'd4) begin
      store_src = {32'b0, req_i.reg_value[63:62], req_i.reg_value[58:29]};
    end
  end

  always_comb begin
    if (req_i.func == rlsf_pkg::FUNC_STORE) begin
      rsp_o.reg_result = '0;
      rsp_o.mem_result = store_val;
      rsp_o.byte_mask  = mask;
    end else begin
      rsp_o.reg_result = load_val;
      rsp_o.mem_result = '0;
      rsp_o.byte_mask  = '0;
    end
  end

endmodule

// File: rtl/register_load_store_formatter.sv
// A request is held in the input register once accepted; its formatted result
// is then registered in the result register once that register is free.
// Throughput: one transaction per cycle while responses are taken; the input
// register and the result register each advance whenever the next stage is free.
// Reset: both stages empty, big_endian 0 and target_mode 0 (plain).
// ----------------------------------------------------------------------------
// Register load/store formatter
// Two-stage data formatter between memory bytes and a 64-bit register.
// ----------------------------------------------------------------------------
module register_load_store_formatter (
  input  logic         clk_i,
  input  logic         rst_ni,
  rlsf_req_if.sink     req,
  rlsf_rsp_if.source   rsp,
  rlsf_cfg_if.sink     cfg
);

  rlsf_pkg::cfg_t cfg_q;
  rlsf_pkg::req_t req_q;
  rlsf_pkg::rsp_t rsp_q;
  rlsf_pkg::rsp_t fmt_rsp;
  logic           s1_valid_q;
  logic           rsp_valid_q;
  logic           s1_adv;
  logic           req_fire;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == rlsf_pkg::REG_BIG_ENDIAN) begin
        cfg_q.big_endian <= cfg.wdata[0];
      end else if (cfg.index == rlsf_pkg::REG_TARGET_MODE) begin
        cfg_q.target_mode <= cfg.wdata[1:0];
      end
    end
  end

  assign s1_adv    = !rsp_valid_q || rsp.ready;
  assign req.ready = !s1_valid_q || s1_adv;
  assign req_fire  = req.valid && req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q.func        <= req.func;
      req_q.reg_kind    <= req.reg_kind;
      req_q.access_size <= req.access_size;
      req_q.mem_bytes   <= req.mem_bytes;
      req_q.reg_value   <= req.reg_value;
    end
    if (s1_adv && s1_valid_q) begin
      rsp_q <= fmt_rsp;
    end
  end

  rlsf_format u_format (
    .cfg_i (cfg_q),
    .req_i (req_q),
    .rsp_o (fmt_rsp)
  );

  assign rsp.valid      = rsp_valid_q;
  assign rsp.reg_result = rsp_q.reg_result;
  assign rsp.mem_result = rsp_q.mem_result;
  assign rsp.byte_mask  = rsp_q.byte_mask;

  // A held input stage must not be dropped while the result register stalls.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("input stage lost a transaction under stall");

  // Byte enables are always a contiguous run starting at byte zero.
  a_mask_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> $onehot0({1'b0, rsp_q.byte_mask} + 9'd1))
    else $error("byte mask is not contiguous");

  // Only stores raise byte enables, and a store returns no register value.
  a_store_reg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.byte_mask != '0) |-> (rsp_q.reg_result == '0))
    else $error("store transaction carries a register value");

endmodule

// File: verif/tb_register_load_store_formatter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Register load/store formatter testbench
// Drives loads and stores through the request channel under every byte order
// and target mode. Each result is predicted and compared field by field, in
// order. Random stalls are placed on both the request and the response side.
// ----------------------------------------------------------------------------
module tb_register_load_store_formatter;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned MaxGap      = 10;
  localparam int unsigned PhaseItems  = 130;
  localparam int unsigned NumPhases   = 12;
  localparam int unsigned MaxReports  = 100;

  // Codes that the block has to tolerate but that carry no function.
  localparam logic [rlsf_pkg::CfgIdxW-1:0] REG_UNUSED  = 2'd3;
  localparam logic [1:0]                   MODE_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  rlsf_req_if req_if ();
  rlsf_rsp_if rsp_if ();
  rlsf_cfg_if cfg_if ();

  register_load_store_formatter u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_if),
    .rsp    (rsp_if),
    .cfg    (cfg_if)
  );

  rlsf_pkg::cfg_t model_cfg;
  rlsf_pkg::rsp_t format_q[$];
  int unsigned    mismatch_cnt = 0;
  int unsigned    cycle_cnt    = 0;
  bit             idle_on      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Maps an 8-bit single-precision exponent onto the 11-bit double range.
  function automatic logic [10:0] widen_exponent(logic [7:0] e);
    if (e == 8'hFF) return 11'h7FF;
    if (e == 8'h00) return 11'h000;
    if (e[7]) return 11'h400 | {4'b0, e[6:0]};
    return 11'h380 | {4'b0, e[6:0]};
  endfunction

  function automatic rlsf_pkg::rsp_t format_access(rlsf_pkg::cfg_t c, rlsf_pkg::req_t r);
    rlsf_pkg::rsp_t o;
    logic [63:0]    v;
    int unsigned    n;
    int unsigned    src;
    logic           sext;
    logic           alpha;
    o     = '0;
    v     = '0;
    n     = (r.access_size > 8) ? 8 : r.access_size;
    sext  = (c.target_mode == rlsf_pkg::MODE_SEXT) ||
            (c.target_mode == rlsf_pkg::MODE_ALPHA);
    alpha = (c.target_mode == rlsf_pkg::MODE_ALPHA);
    if (r.func == rlsf_pkg::FUNC_LOAD) begin
      for (int i = 0; i < n; i++) begin
        if (c.big_endian) begin
          v = {v[55:0], r.mem_bytes[8*i +: 8]};
        end else begin
          v[8*i +: 8] = r.mem_bytes[8*i +: 8];
        end
      end
      if (n == 4) begin
        if (r.reg_kind == rlsf_pkg::KIND_INT && sext) begin
          v = {{32{v[31]}}, v[31:0]};
        end else if (r.reg_kind == rlsf_pkg::KIND_FLOAT && alpha) begin
          v = {v[31], widen_exponent(v[30:23]), v[22:0], 29'b0};
        end
      end
      o.reg_result = v;
    end else begin
      v = r.reg_value;
      // A 4-byte Alpha float keeps the sign, the exponent top bit and 30 bits
      // below the T_Floating exponent's upper bits.
      if (r.reg_kind == rlsf_pkg::KIND_FLOAT && alpha && n == 4) begin
        v = {32'b0, v[63:62], v[58:29]};
      end
      for (int i = 0; i < n; i++) begin
        src = c.big_endian ? (n - 1 - i) : i;
        o.mem_result[8*i +: 8] = v[8*src +: 8];
        o.byte_mask[i]         = 1'b1;
      end
    end
    return o;
  endfunction

  // Lays a 32-bit word into the low four memory bytes in the current order.
  function automatic logic [31:0] place_word(logic [31:0] w);
    if (model_cfg.big_endian) return {w[7:0], w[15:8], w[23:16], w[31:24]};
    return w;
  endfunction

  function automatic rlsf_pkg::req_t random_access();
    rlsf_pkg::req_t r;
    logic [31:0]    w;
    int unsigned    pick;
    r.func      = 1'($urandom_range(0, 1));
    r.reg_kind  = 1'($urandom_range(0, 1));
    r.mem_bytes = {$urandom, $urandom};
    r.reg_value = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.access_size = 4'd4;
    end else if (pick < 90) begin
      r.access_size = 4'($urandom_range(0, 8));
    end else begin
      r.access_size = 4'($urandom_range(9, 15));
    end
    // Steer some 4-byte loads onto the exponent values that map specially.
    if (r.access_size == 4'd4 && $urandom_range(0, 3) == 0) begin
      w = $urandom;
      case ($urandom_range(0, 3))
        0: w[30:23] = 8'h00;
        1: w[30:23] = 8'hFF;
        2: w[30:23] = 8'h80;
        default: w[30:23] = 8'h7F;
      endcase
      r.mem_bytes[31:0] = place_word(w);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) begin
      $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $time);
    end
  endtask

  always @(posedge clk) begin : result_check
    rlsf_pkg::rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (format_q.size() == 0) begin
        report_mismatch("result without a request", rsp_if.reg_result, '0);
      end else begin
        want = format_q.pop_front();
        if (rsp_if.reg_result !== want.reg_result) begin
          report_mismatch("reg_result", rsp_if.reg_result, want.reg_result);
        end
        if (rsp_if.mem_result !== want.mem_result) begin
          report_mismatch("mem_result", rsp_if.mem_result, want.mem_result);
        end
        if (rsp_if.byte_mask !== want.byte_mask) begin
          report_mismatch("byte_mask", {56'b0, rsp_if.byte_mask}, {56'b0, want.byte_mask});
        end
      end
    end
  end

  // While idle_on is set, the response side holds ready low for a random stall,
  // possibly none, before each transaction.
  initial begin : result_ready
    int unsigned stall;
    rsp_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, MaxGap) : 0;
      @(negedge clk);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  task automatic send_access(input rlsf_pkg::req_t r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= r.func;
    req_if.reg_kind    <= r.reg_kind;
    req_if.access_size <= r.access_size;
    req_if.mem_bytes   <= r.mem_bytes;
    req_if.reg_value   <= r.reg_value;
    do @(posedge clk); while (!req_if.ready);
    format_q.push_back(format_access(model_cfg, r));
  endtask

  task automatic send_op(input logic func, input logic kind, input int unsigned size,
                         input logic [63:0] mem, input logic [63:0] regv);
    rlsf_pkg::req_t r;
    r.func        = func;
    r.reg_kind    = kind;
    r.access_size = 4'(size);
    r.mem_bytes   = mem;
    r.reg_value   = regv;
    send_access(r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (format_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [rlsf_pkg::CfgIdxW-1:0] idx,
                                input logic [rlsf_pkg::CfgDataW-1:0] data);
    drain_results();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      rlsf_pkg::REG_BIG_ENDIAN:  model_cfg.big_endian  = data[0];
      rlsf_pkg::REG_TARGET_MODE: model_cfg.target_mode = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_INT, 8, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_op(rlsf_pkg::FUNC_STORE, rlsf_pkg::KIND_INT, 8, 64'h0, 64'h0123_4567_89AB_CDEF);
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_FLOAT, 0, 64'hFFFF_FFFF_FFFF_FFFF,
            64'hFFFF_FFFF_FFFF_FFFF);
    send_op(rlsf_pkg::FUNC_STORE, rlsf_pkg::KIND_FLOAT, 0, 64'hFFFF_FFFF_FFFF_FFFF,
            64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_sign_extend();
    write_register(rlsf_pkg::REG_TARGET_MODE, {6'd0, rlsf_pkg::MODE_SEXT});
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_INT, 4, 64'hFFFF_FFFF_8000_0001, 64'h0);
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_INT, 4, 64'h0123_4567_7FFF_FFFF, 64'h0);
    // A float load in this mode is assembled without any exponent mapping.
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_FLOAT, 4, 64'hFFFF_FFFF_C0A0_0000, 64'h0);
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_INT, 15, 64'h8877_6655_4433_2211, 64'h0);
    send_op(rlsf_pkg::FUNC_STORE, rlsf_pkg::KIND_INT, 4, 64'h0, 64'hDEAD_BEEF_CAFE_F00D);
  endtask

  task automatic test_alpha_float();
    write_register(rlsf_pkg::REG_BIG_ENDIAN, 8'hFF);
    write_register(rlsf_pkg::REG_TARGET_MODE, 8'hFE);
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_FLOAT, 4,
            {32'hA5A5_A5A5, place_word(32'hFF80_0001)}, 64'h0);
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_FLOAT, 4,
            {32'h0, place_word(32'h0000_0001)}, 64'h0);
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_FLOAT, 4,
            {32'h0, place_word(32'h4049_0FDB)}, 64'h0);
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_FLOAT, 4,
            {32'h0, place_word(32'h3F80_0000)}, 64'h0);
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_FLOAT, 4,
            {32'h0, place_word(32'hBF00_0000)}, 64'h0);
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_INT, 4,
            {32'hFFFF_FFFF, place_word(32'h8000_0000)}, 64'h0);
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_FLOAT, 8, 64'h0102_0304_0506_0708, 64'h0);
    send_op(rlsf_pkg::FUNC_STORE, rlsf_pkg::KIND_FLOAT, 4, 64'h0, 64'hC009_21FB_5444_2D18);
    send_op(rlsf_pkg::FUNC_STORE, rlsf_pkg::KIND_FLOAT, 8, 64'h0, 64'hC009_21FB_5444_2D18);
    send_op(rlsf_pkg::FUNC_STORE, rlsf_pkg::KIND_INT, 9, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_unused_codes();
    // A write to the free index must leave both registers as they are.
    write_register(REG_UNUSED, 8'h02);
    write_register(rlsf_pkg::REG_TARGET_MODE, {6'h3F, MODE_UNUSED});
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_INT, 4,
            {32'h0, place_word(32'h8000_0000)}, 64'h0);
    send_op(rlsf_pkg::FUNC_STORE, rlsf_pkg::KIND_FLOAT, 4, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(rlsf_pkg::FUNC_LOAD, rlsf_pkg::KIND_FLOAT, 4,
            {32'h0, place_word(32'hFF80_0000)}, 64'h0);
  endtask

  task automatic test_random();
    logic       order;
    logic [1:0] mode;
    for (int phase = 0; phase < NumPhases; phase++) begin
      order = phase[0];
      mode  = 2'((phase / 2) % 4);
      write_register(rlsf_pkg::REG_BIG_ENDIAN, {7'($urandom_range(0, 127)), order});
      write_register(rlsf_pkg::REG_TARGET_MODE, {6'($urandom_range(0, 63)), mode});
      // Every third phase runs with both sides at full rate.
      idle_on = (phase % 3 != 2);
      for (int k = 0; k < PhaseItems; k++) begin
        send_access(random_access());
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    req_if.valid       = 1'b0;
    req_if.func        = rlsf_pkg::FUNC_LOAD;
    req_if.reg_kind    = rlsf_pkg::KIND_INT;
    req_if.access_size = '0;
    req_if.mem_bytes   = '0;
    req_if.reg_value   = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = rlsf_pkg::REG_BIG_ENDIAN;
    cfg_if.wdata       = '0;
    model_cfg          = '0;
    rst_n              = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_sign_extend();
    test_alpha_float();
    test_unused_codes();
    test_random();
    drain_results();

    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
